// ----- sv/nbt_pkg.sv -----
// Types, codes and constants shared by the binding table modules.
`timescale 1ns / 1ps
`default_nettype none
package nbt_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CSR_ADDR_W    = 4;

   localparam logic [31:0] POOL_FIRST_RESET = 32'h6440_0001;
   localparam logic [31:0] POOL_LAST_RESET  = 32'h647F_FFFE;
   localparam logic [31:0] EXPIRE_RESET     = 32'd1000;

   localparam logic [1:0] REG_POOL_FIRST = 2'd0;
   localparam logic [1:0] REG_POOL_LAST  = 2'd1;
   localparam logic [1:0] REG_EXPIRE     = 2'd2;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_V6_TO_V4,
      CMD_V4_TO_V6
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_NEW,
      ST_EXHAUSTED,
      ST_NO_ENTRY,
      ST_FULL
   } status_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] v6_high;
      logic [63:0] v6_low;
      logic [31:0] v4_in;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] v4_out;
      logic [63:0] v6_out_high;
      logic [63:0] v6_out_low;
   } rsp_type;

   typedef struct packed {
      logic [63:0] v6_high;
      logic [63:0] v6_low;
      logic [31:0] v4;
   } entry_type;

   typedef struct packed {
      logic [IDX_W-1:0] rd_addr;
      logic [IDX_W-1:0] wr_addr;
      logic             wr_entry;
      logic             wr_stamp;
      logic             clr_valid;
      entry_type        entry;
      logic [31:0]      stamp;
   } store_req_type;

   typedef struct packed {
      logic        valid;
      entry_type   entry;
      logic [31:0] stamp;
   } store_rsp_type;

   typedef struct packed {
      logic [31:0] pool_last;
      logic [31:0] expire;
      logic [32:0] next_pool;
   } cfg_type;

endpackage
`default_nettype wire

// ----- sv/nbt_csr.sv -----
// Configuration registers and the pool pointer.
`timescale 1ns / 1ps
`default_nettype none
module nbt_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [nbt_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                     pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready,
   input  wire logic                            pool_inc,
   output nbt_pkg::cfg_type                     cfg
);
   import nbt_pkg::*;

   logic [31:0] pool_first_ff, pool_first_in;
   logic [31:0] pool_last_ff, pool_last_in;
   logic [31:0] expire_ff, expire_in;
   logic [32:0] next_pool_ff, next_pool_in;
   logic        wr_beat;

   assign pready  = 1'b1;
   assign wr_beat = psel & penable & pwrite;

   always_comb begin
      pool_first_in = pool_first_ff;
      pool_last_in  = pool_last_ff;
      expire_in     = expire_ff;
      next_pool_in  = pool_inc ? next_pool_ff + 33'd1 : next_pool_ff;
      if (wr_beat) begin
         case (paddr[3:2])
            REG_POOL_FIRST: begin
               pool_first_in = pwdata;
               next_pool_in  = {1'b0, pwdata};
            end
            REG_POOL_LAST: pool_last_in = pwdata;
            REG_EXPIRE:    expire_in    = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_POOL_FIRST: prdata = pool_first_ff;
         REG_POOL_LAST:  prdata = pool_last_ff;
         REG_EXPIRE:     prdata = expire_ff;
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_first_ff <= POOL_FIRST_RESET;
         pool_last_ff  <= POOL_LAST_RESET;
         expire_ff     <= EXPIRE_RESET;
         next_pool_ff  <= {1'b0, POOL_FIRST_RESET};
      end else begin
         pool_first_ff <= pool_first_in;
         pool_last_ff  <= pool_last_in;
         expire_ff     <= expire_in;
         next_pool_ff  <= next_pool_in;
      end
   end

   assign cfg.pool_last = pool_last_ff;
   assign cfg.expire    = expire_ff;
   assign cfg.next_pool = next_pool_ff;

endmodule
`default_nettype wire

// ----- sv/nbt_store.sv -----
// Entry memories with registered read and per-entry valid flags.
`timescale 1ns / 1ps
`default_nettype none
module nbt_store (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire nbt_pkg::store_req_type req,
   output nbt_pkg::store_rsp_type      rsp
);
   import nbt_pkg::*;

   logic [TABLE_ENTRIES-1:0] valid_ff;
   entry_type                entry_mem_ff [TABLE_ENTRIES];
   logic [31:0]              stamp_mem_ff [TABLE_ENTRIES];
   logic                     rd_valid_ff;
   entry_type                rd_entry_ff;
   logic [31:0]              rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (req.wr_entry) begin
         valid_ff[req.wr_addr] <= 1'b1;
      end else if (req.clr_valid) begin
         valid_ff[req.wr_addr] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[req.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (req.wr_entry) begin
         entry_mem_ff[req.wr_addr] <= req.entry;
      end
      rd_entry_ff <= entry_mem_ff[req.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (req.wr_stamp) begin
         stamp_mem_ff[req.wr_addr] <= req.stamp;
      end
      rd_stamp_ff <= stamp_mem_ff[req.rd_addr];
   end

   assign rsp.valid = rd_valid_ff;
   assign rsp.entry = rd_entry_ff;
   assign rsp.stamp = rd_stamp_ff;

endmodule
`default_nettype wire

// ----- sv/nbt_seq.sv -----
// Sequencer: match sweep, reclaim sweep and binding over the shared compare.
`timescale 1ns / 1ps
`default_nettype none
module nbt_seq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire nbt_pkg::req_type       req_item,
   output logic                        rsp_valid,
   output nbt_pkg::rsp_type            rsp_item,
   input  wire nbt_pkg::cfg_type       cfg,
   output logic                        pool_inc,
   output nbt_pkg::store_req_type      st_req,
   input  wire nbt_pkg::store_rsp_type st_rsp
);
   import nbt_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_RECLAIM,
      S_DECIDE
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [31:0]      tick_ff, tick_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             issue_ff, issue_in;
   logic             pvld_ff, pvld_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   logic             plast_ff, plast_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             addr_last;
   logic             hit;
   logic             expired;
   logic [31:0]      age;

   assign addr_last = (addr_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign age       = tick_ff - st_rsp.stamp;
   assign expired   = st_rsp.valid && (age > cfg.expire);

   always_comb begin
      if (req_ff.command == CMD_V6_TO_V4) begin
         hit = st_rsp.valid && (st_rsp.entry.v6_high == req_ff.v6_high)
               && (st_rsp.entry.v6_low == req_ff.v6_low);
      end else begin
         hit = st_rsp.valid && (st_rsp.entry.v4 == req_ff.v4_in);
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      tick_in       = tick_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      pvld_in       = 1'b0;
      pidx_in       = pidx_ff;
      plast_in      = plast_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      pool_inc      = 1'b0;

      st_req.rd_addr   = addr_ff;
      st_req.wr_addr   = pidx_ff;
      st_req.wr_entry  = 1'b0;
      st_req.wr_stamp  = 1'b0;
      st_req.clr_valid = 1'b0;
      st_req.entry.v6_high = req_ff.v6_high;
      st_req.entry.v6_low  = req_ff.v6_low;
      st_req.entry.v4      = cfg.next_pool[31:0];
      st_req.stamp     = tick_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in        = req_item;
               rsp_in        = '0;
               rsp_in.status = ST_OK;
               case (req_item.command)
                  CMD_TICK: begin
                     tick_in      = tick_ff + 32'd1;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_V6_TO_V4, CMD_V4_TO_V6: begin
                     state_in = S_MATCH;
                     addr_in  = '0;
                     issue_in = 1'b1;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_MATCH, S_RECLAIM: begin
            // read issue runs ahead of the compare through the registered read port
            pvld_in  = issue_ff;
            pidx_in  = addr_ff;
            plast_in = addr_last;
            if (issue_ff) begin
               addr_in = addr_ff + IDX_W'(1);
               if (addr_last) begin
                  issue_in = 1'b0;
               end
            end
            if (state_ff == S_MATCH) begin
               if (pvld_ff) begin
                  if (hit) begin
                     st_req.wr_stamp = 1'b1;
                     rsp_valid_in    = 1'b1;
                     rsp_in          = '0;
                     rsp_in.status   = ST_OK;
                     if (req_ff.command == CMD_V6_TO_V4) begin
                        rsp_in.v4_out = st_rsp.entry.v4;
                     end else begin
                        rsp_in.v6_out_high = st_rsp.entry.v6_high;
                        rsp_in.v6_out_low  = st_rsp.entry.v6_low;
                     end
                     state_in = S_IDLE;
                     pvld_in  = 1'b0;
                     issue_in = 1'b0;
                  end else if (plast_ff) begin
                     if (req_ff.command == CMD_V4_TO_V6) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in        = '0;
                        rsp_in.status = ST_NO_ENTRY;
                        state_in      = S_IDLE;
                        pvld_in       = 1'b0;
                     end else begin
                        state_in      = S_RECLAIM;
                        addr_in       = '0;
                        issue_in      = 1'b1;
                        pvld_in       = 1'b0;
                        free_found_in = 1'b0;
                     end
                  end
               end
            end else begin
               if (pvld_ff) begin
                  st_req.clr_valid = expired;
                  if (!free_found_ff && (!st_rsp.valid || expired)) begin
                     free_found_in = 1'b1;
                     free_idx_in   = pidx_ff;
                  end
                  if (plast_ff) begin
                     state_in = S_DECIDE;
                     pvld_in  = 1'b0;
                  end
               end
            end
         end
         S_DECIDE: begin
            rsp_valid_in   = 1'b1;
            rsp_in         = '0;
            state_in       = S_IDLE;
            st_req.wr_addr = free_idx_ff;
            if (cfg.next_pool > {1'b0, cfg.pool_last}) begin
               rsp_in.status = ST_EXHAUSTED;
            end else if (!free_found_ff) begin
               rsp_in.status = ST_FULL;
            end else begin
               st_req.wr_entry = 1'b1;
               st_req.wr_stamp = 1'b1;
               pool_inc        = 1'b1;
               rsp_in.status   = ST_NEW;
               rsp_in.v4_out   = cfg.next_pool[31:0];
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tick_ff       <= 32'd0;
         issue_ff      <= 1'b0;
         pvld_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         issue_ff      <= issue_in;
         pvld_ff       <= pvld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff        <= req_in;
      addr_ff       <= addr_in;
      pidx_ff       <= pidx_in;
      plast_ff      <= plast_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      rsp_ff        <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire

// ----- sv/nat64_binding_table.sv -----
// Top level of the NAT64 address binding table.
//
//   channel   ports                                   handshake
//   request   start, busy, req_item                   taken when start & !busy
//   response  rsp_valid, rsp_item                     one-cycle strobe, no stall
//   csr       psel, penable, pwrite, paddr, pwdata,   APB, pready tied high
//             prdata, pready
//
// Tick and unused commands answer on the next cycle without raising busy.
// Lookups sweep the table one entry per cycle through the registered read
// port; a hit ends the sweep early, and a v4 miss answers after the full sweep.
// A v6 miss adds a reclaim sweep and a bind step in S_DECIDE.
// Synchronous reset clears valid flags and tick counter and reloads the pool pointer at once.
// Responses cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module nat64_binding_table (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire nbt_pkg::req_type               req_item,
   output logic                                rsp_valid,
   output nbt_pkg::rsp_type                    rsp_item,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [nbt_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                    pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import nbt_pkg::*;

   cfg_type       cfg;
   logic          pool_inc;
   store_req_type st_req;
   store_rsp_type st_rsp;

   nbt_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .pool_inc (pool_inc),
      .cfg      (cfg)
   );

   nbt_store u_store (
      .clock (clock),
      .reset (reset),
      .req   (st_req),
      .rsp   (st_rsp)
   );

   nbt_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .cfg       (cfg),
      .pool_inc  (pool_inc),
      .st_req    (st_req),
      .st_rsp    (st_rsp)
   );

endmodule
`default_nettype wire

// ----- sv/nbt_checker.sv -----
// Port-level checks on the binding table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module nbt_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire nbt_pkg::req_type req_item,
   input wire logic             rsp_valid,
   input wire nbt_pkg::rsp_type rsp_item
);
   import nbt_pkg::*;

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("busy or response after reset");

   a_tick_answer: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.command == CMD_TICK
      |=> rsp_valid && rsp_item.status == ST_OK)
      else $error("tick not answered on the next beat");

   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy raised without a request");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still busy");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != ST_OK && rsp_item.status != ST_NEW
      |-> rsp_item.v4_out == 32'd0 && rsp_item.v6_out_high == 64'd0
          && rsp_item.v6_out_low == 64'd0)
      else $error("error response carries an address");

endmodule

bind nat64_binding_table nbt_checker u_nbt_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
`default_nettype wire
